/* hdl/idwt53_pkg.sv */
`timescale 1ns / 1ps

package idwt53_pkg;

    localparam int SAMPLE_BITS_DEF = 24;

    // Results one coefficient can release, and the output queue that absorbs them
    localparam int MAX_RES       = 3;
    localparam int RES_CNT_BITS  = $clog2(MAX_RES + 1);
    localparam int OUTQ_DEPTH    = 8;
    localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);

    typedef struct packed {
        logic [RES_CNT_BITS-1:0] cnt;   // number of result slots to write
        logic [MAX_RES-1:0]      ends;  // line end flag per slot
    } push_ctl_t;

endpackage

/* hdl/idwt53_lift.sv */
`timescale 1ns / 1ps

module idwt53_lift
    import idwt53_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          item_valid,
    input  logic signed [SAMPLE_BITS-1:0] item_sample,
    input  logic                          item_last,
    output push_ctl_t                     push,
    output logic signed [SAMPLE_BITS-1:0] res_data [MAX_RES]
);

    localparam int EW = SAMPLE_BITS + 2;
    localparam logic [1:0] POS_START = 2'd0;
    localparam logic [1:0] POS_FULL  = 2'd3;

    logic                          start_odd_reg;
    logic [1:0]                    pos_reg;
    logic [1:0]                    pos_next;
    logic                          phase_reg;
    logic                          phase_next;
    logic signed [SAMPLE_BITS-1:0] r0_reg;
    logic signed [SAMPLE_BITS-1:0] r1_reg;
    logic signed [SAMPLE_BITS-1:0] last_even_reg;

    logic                          phase;
    logic signed [SAMPLE_BITS-1:0] op_a;
    logic signed [SAMPLE_BITS-1:0] op_b;
    logic signed [SAMPLE_BITS-1:0] op_p;
    logic signed [SAMPLE_BITS-1:0] even_prev;
    logic signed [EW-1:0]          upd_sum;
    logic signed [EW-1:0]          upd_diff;
    logic signed [SAMPLE_BITS-1:0] even_val;
    logic signed [EW-1:0]          pred_avg;
    logic signed [SAMPLE_BITS-1:0] odd_val;
    logic signed [SAMPLE_BITS-1:0] tail_val;
    logic signed [SAMPLE_BITS-1:0] half_val;

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [EW-1:0] v);
        logic [EW-SAMPLE_BITS:0] top;
        top = v[EW-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
            return v[SAMPLE_BITS-1:0];
        else if (v[EW-1])
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    assign phase = (pos_reg == POS_START) ? start_odd_reg : phase_reg;

    // Undo update: even = a - floor((b + c + 2) / 4), end neighbours mirrored
    always_comb
    begin
        if (!phase)
        begin
            op_a      = item_sample;
            op_b      = r0_reg;
            op_p      = r0_reg;
            even_prev = (pos_reg >= 2'd2) ? last_even_reg : even_val;
        end
        else
        begin
            op_a      = r0_reg;
            op_b      = (pos_reg >= 2'd2) ? r1_reg : item_sample;
            op_p      = r1_reg;
            even_prev = (pos_reg == POS_FULL) ? last_even_reg : even_val;
        end
    end

    always_comb
    begin
        upd_sum  = EW'(op_b) + EW'(phase ? item_sample : r0_reg) + EW'(2);
        upd_diff = EW'(op_a) - (upd_sum >>> 2);
        even_val = sat(upd_diff);
        pred_avg = (EW'(even_prev) + EW'(even_val)) >>> 1;
        odd_val  = sat(EW'(op_p) + pred_avg);
        tail_val = sat(EW'(item_sample) + EW'(even_val));
        half_val = item_sample >>> 1;
    end

    always_comb
    begin
        push.cnt  = '0;
        push.ends = '0;
        for (int i = 0; i < MAX_RES; i++)
            res_data[i] = even_val;
        if (item_valid)
        begin
            if (!phase)
            begin
                if (item_last && pos_reg == POS_START)
                begin
                    push.cnt    = RES_CNT_BITS'(1);
                    push.ends   = MAX_RES'(3'b001);
                    res_data[0] = item_sample;
                end
                else if (item_last)
                begin
                    push.cnt    = RES_CNT_BITS'(2);
                    push.ends   = MAX_RES'(3'b010);
                    res_data[0] = odd_val;
                    res_data[1] = even_val;
                end
            end
            else if (pos_reg == POS_START)
            begin
                if (item_last)
                begin
                    push.cnt    = RES_CNT_BITS'(1);
                    push.ends   = MAX_RES'(3'b001);
                    res_data[0] = half_val;
                end
            end
            else if (pos_reg >= 2'd2)
            begin
                push.cnt    = item_last ? RES_CNT_BITS'(3) : RES_CNT_BITS'(2);
                push.ends   = item_last ? MAX_RES'(3'b100) : '0;
                res_data[0] = odd_val;
                res_data[1] = even_val;
                res_data[2] = tail_val;
            end
            else
            begin
                push.cnt    = item_last ? RES_CNT_BITS'(2) : RES_CNT_BITS'(1);
                push.ends   = item_last ? MAX_RES'(3'b010) : '0;
                res_data[0] = even_val;
                res_data[1] = tail_val;
            end
        end
    end

    always_comb
    begin
        if (item_last)
        begin
            pos_next   = POS_START;
            phase_next = 1'b0;
        end
        else
        begin
            pos_next   = (pos_reg == POS_FULL) ? POS_FULL : pos_reg + 2'd1;
            phase_next = ~phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_odd_reg <= 1'b0;
            pos_reg       <= POS_START;
            phase_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                start_odd_reg <= cfg_wdata;
            if (item_valid)
            begin
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
            end
        end
    end

    // Sample history is only read once the line has filled it
    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            r1_reg <= r0_reg;
            r0_reg <= item_sample;
            if (phase && pos_reg != POS_START)
                last_even_reg <= even_val;
        end
    end

    a_three_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == RES_CNT_BITS'(3) |-> push.ends == MAX_RES'(3'b100))
        else $error("three results without line end on the last slot");

    a_no_end_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_last |-> push.ends == '0)
        else $error("line end flagged before the last coefficient");

    a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_last |=> pos_reg == POS_START && phase_reg == 1'b0)
        else $error("line position not cleared after line end");

endmodule

/* hdl/idwt53_outq.sv */
`timescale 1ns / 1ps

module idwt53_outq
    import idwt53_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  push_ctl_t                     push,
    input  logic signed [SAMPLE_BITS-1:0] push_data [MAX_RES],
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic                          out_last
);

    logic signed [SAMPLE_BITS-1:0] q_data [OUTQ_DEPTH];
    logic                          q_last [OUTQ_DEPTH];
    logic [OUTQ_PTR_BITS-1:0]      wr_ptr_reg;
    logic [OUTQ_PTR_BITS-1:0]      rd_ptr_reg;
    logic [OUTQ_PTR_BITS:0]        count_reg;
    logic [OUTQ_PTR_BITS:0]        count_next;
    logic                          pop;

    assign out_valid  = (count_reg != '0);
    assign out_sample = q_data[rd_ptr_reg];
    assign out_last   = q_last[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    // Accept a new item only if a worst-case burst still fits
    assign room       = (count_reg <= (OUTQ_PTR_BITS+1)'(OUTQ_DEPTH - MAX_RES));
    assign count_next = count_reg + (OUTQ_PTR_BITS+1)'(push.cnt)
                        - (OUTQ_PTR_BITS+1)'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if ((RES_CNT_BITS+1)'(i) < (RES_CNT_BITS+1)'(push.cnt))
            begin
                q_data[wr_ptr_reg + OUTQ_PTR_BITS'(i)] <= push_data[i];
                q_last[wr_ptr_reg + OUTQ_PTR_BITS'(i)] <= push.ends[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_BITS'(push.cnt);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_BITS'(1);
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (OUTQ_PTR_BITS+1)'(OUTQ_DEPTH))
        else $error("output queue count beyond depth");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != '0 |->
            count_reg + (OUTQ_PTR_BITS+1)'(push.cnt) <= (OUTQ_PTR_BITS+1)'(OUTQ_DEPTH))
        else $error("output queue overflow on push");

endmodule

/* hdl/inverse_dwt_53_reversible_line.sv */
`timescale 1ns / 1ps

// Channel     Direction  Payload
// s_axis      in         tdata: sample_in; tlast: is_last
// m_axis      out        tdata: sample_out; tlast: line_end
// cfg         in         cfg_wdata: start_odd, written when cfg_we is high
//
// One coefficient is accepted per cycle unless stalled; the input register holds it
// until the lifting logic writes its zero to three results into an 8-entry output queue.
// Results leave one per cycle if m_axis_tready is high; N coefficients yield N results.
// The input stalls only while the output queue holds more than five results.
// Reset (rst_n, asynchronous) empties both stages and restarts the line.
module inverse_dwt_53_reversible_line
    import idwt53_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_BITS-1:0] s_axis_tdata,   // sample_in
    input  logic                 s_axis_tlast,   // is_last
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_BITS-1:0] m_axis_tdata,   // sample_out
    output logic                 m_axis_tlast    // line_end
);

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_last_reg;
    logic                          room;
    logic                          advance;
    push_ctl_t                     push;
    logic signed [SAMPLE_BITS-1:0] res_data [MAX_RES];
    logic signed [SAMPLE_BITS-1:0] out_sample;

    assign advance       = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || room;
    assign m_axis_tdata  = DATA_BITS'($unsigned(out_sample));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            in_last_reg   <= s_axis_tlast;
        end
    end

    idwt53_lift #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lift (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_valid  (advance),
        .item_sample (in_sample_reg),
        .item_last   (in_last_reg),
        .push        (push),
        .res_data    (res_data)
    );

    idwt53_outq #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (res_data),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (out_sample),
        .out_last   (m_axis_tlast)
    );

endmodule

/* tb/tb_inverse_dwt_53_reversible_line.sv */
`timescale 1ns / 1ps

module tb_inverse_dwt_53_reversible_line;
    import idwt53_pkg::*;

    localparam int SB         = SAMPLE_BITS_DEF;
    localparam int DB         = ((SB + 7) / 8) * 8;
    localparam int STALL_MAX  = 19;
    localparam int SETTLE     = 8;
    localparam int WATCHDOG   = 2000;
    localparam int RAND_ITEMS = 28;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    typedef struct {
        logic signed [SB-1:0] sample;
        bit                   last;
    } coeff_t;

    typedef struct {
        logic [SB-1:0] sample;
        bit            line_end;
    } recon_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic          cfg_wdata = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DB-1:0] s_axis_tdata = '0;   // sample_in
    logic          s_axis_tlast = 1'b0; // is_last
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [DB-1:0] m_axis_tdata;        // sample_out
    logic          m_axis_tlast;        // line_end

    // predictor state
    bit                   start_odd_q;
    logic signed [SB-1:0] prev0_q;
    logic signed [SB-1:0] prev1_q;
    logic signed [SB-1:0] last_even_q;
    bit [1:0]             pos_q;
    bit                   phase_q;

    coeff_t coeff_q[$];
    recon_t pending_recon[$];

    bit send_idle;
    bit recv_idle;
    int gap_left;
    int stall_left;
    int recv_wait;
    int mismatches = 0;
    int quiet_cycles = 0;

    inverse_dwt_53_reversible_line dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [SB-1:0] clamp(longint v);
        if (v > longint'(S_MAX))
            return S_MAX;
        if (v < longint'(S_MIN))
            return S_MIN;
        return v[SB-1:0];
    endfunction

    function automatic void expect_sample(longint v, bit line_end);
        recon_t r;
        r.sample   = v[SB-1:0];
        r.line_end = line_end;
        pending_recon.push_back(r);
    endfunction

    // Undo update then predict; arithmetic shift gives the floor division
    function automatic void lift_predict(logic signed [SB-1:0] xs, bit last);
        longint               x;
        longint               dp;
        longint               ep;
        logic signed [SB-1:0] e;
        bit [1:0]             p;
        bit                   ph;
        x  = xs;
        p  = pos_q;
        ph = (p == 0) ? start_odd_q : phase_q;
        if (!ph)
        begin
            if (last)
            begin
                if (p == 0)
                    expect_sample(x, 1'b1);
                else
                begin
                    e  = clamp(x - ((2 * longint'(prev0_q) + 2) >>> 2));
                    ep = (p >= 2) ? longint'(last_even_q) : longint'(e);
                    expect_sample(clamp(longint'(prev0_q) + ((ep + e) >>> 1)), 1'b0);
                    expect_sample(e, 1'b1);
                end
            end
        end
        else
        begin
            if (p >= 1)
            begin
                dp = (p >= 2) ? longint'(prev1_q) : x;
                e  = clamp(longint'(prev0_q) - ((dp + x + 2) >>> 2));
                if (p >= 2)
                begin
                    ep = (p >= 3) ? longint'(last_even_q) : longint'(e);
                    expect_sample(clamp(longint'(prev1_q) + ((ep + e) >>> 1)), 1'b0);
                end
                expect_sample(e, 1'b0);
                last_even_q = e;
                if (last)
                    expect_sample(clamp(x + e), 1'b1);
            end
            else if (last)
                expect_sample(x >>> 1, 1'b1);
        end
        prev1_q = prev0_q;
        prev0_q = xs;
        if (last)
        begin
            pos_q   = 0;
            phase_q = 1'b0;
        end
        else
        begin
            pos_q   = (p == 3) ? 2'd3 : p + 2'd1;
            phase_q = ~ph;
        end
    endfunction

    function automatic int draw_wait(bit on);
        return on ? int'($urandom_range(0, STALL_MAX)) : 0;
    endfunction

    function automatic logic signed [SB-1:0] draw_coeff();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2, 3, 4: return SB'(int'($urandom_range(0, 64)) - 32);
            default: return SB'($urandom());
        endcase
    endfunction

    // sender: present queued coefficients, hold while not ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            gap_left      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                lift_predict(s_axis_tdata[SB-1:0], s_axis_tlast);
            if (s_axis_tvalid && !s_axis_tready)
                ;
            else if (gap_left != 0)
            begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (coeff_q.size() != 0)
            begin
                s_axis_tdata  <= DB'(coeff_q[0].sample);
                s_axis_tlast  <= coeff_q[0].last;
                s_axis_tvalid <= 1'b1;
                gap_left      <= draw_wait(send_idle);
                void'(coeff_q.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: check each transfer against the oldest expected sample
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_recon.size() == 0)
            begin
                $error("unexpected transfer: sample_out %0d line_end %0b",
                       $signed(m_axis_tdata[SB-1:0]), m_axis_tlast);
                mismatches++;
            end
            else
            begin
                if (m_axis_tdata[SB-1:0] !== pending_recon[0].sample)
                begin
                    $error("sample_out: expected %0d, got %0d",
                           $signed(pending_recon[0].sample), $signed(m_axis_tdata[SB-1:0]));
                    mismatches++;
                end
                if (m_axis_tlast !== pending_recon[0].line_end)
                begin
                    $error("line_end: expected %0b, got %0b",
                           pending_recon[0].line_end, m_axis_tlast);
                    mismatches++;
                end
                void'(pending_recon.pop_front());
            end
            recv_wait      = draw_wait(recv_idle);
            stall_left    <= recv_wait;
            m_axis_tready <= (recv_wait == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_coeff(logic signed [SB-1:0] v, bit last);
        coeff_t c;
        c.sample = v;
        c.last   = last;
        coeff_q.push_back(c);
    endtask

    // hold off until the stream has drained, then let the pipeline settle
    task automatic wait_drained();
        while (coeff_q.size() != 0 || s_axis_tvalid || pending_recon.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_start_odd(bit v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we      <= 1'b0;
        start_odd_q = v;
    endtask

    initial
    begin
        int sent;
        int len;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // even first sample: pass-through singles, mirrored ends, saturation
        write_start_odd(1'b0);
        push_coeff(S_MAX, 1'b1);
        push_coeff(S_MIN, 1'b1);
        push_coeff(S_MIN, 1'b0);
        push_coeff(S_MAX, 1'b1);
        push_coeff(S_MAX, 1'b0);
        push_coeff(S_MIN, 1'b0);
        push_coeff(S_MAX, 1'b1);
        push_coeff(S_MIN, 1'b0);
        push_coeff(S_MAX, 1'b0);
        push_coeff(S_MIN, 1'b0);
        push_coeff(S_MAX, 1'b0);
        push_coeff(S_MIN, 1'b1);
        // start a line, then change the register before it ends
        push_coeff(SB'(5), 1'b0);
        push_coeff(SB'(-7), 1'b0);
        wait_drained();
        write_start_odd(1'b1);
        push_coeff(SB'(9), 1'b0);
        push_coeff(SB'(3), 1'b1);
        wait_drained();

        // odd first sample: halved singles and saturating short lines
        push_coeff(S_MIN, 1'b1);
        push_coeff(S_MAX, 1'b1);
        push_coeff(SB'(-1), 1'b1);
        push_coeff(S_MAX, 1'b0);
        push_coeff(S_MIN, 1'b1);
        push_coeff(S_MIN, 1'b0);
        push_coeff(S_MAX, 1'b0);
        push_coeff(S_MIN, 1'b0);
        push_coeff(S_MAX, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = ph[0];
            recv_idle = ph[1];
            write_start_odd(ph < 2 ? ph[0] : 1'($urandom_range(0, 1)));
            sent = 0;
            while (sent < RAND_ITEMS)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30)
                                                  : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    push_coeff(draw_coeff(), i == len - 1);
                sent += len;
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hdl/idwt53_pkg.sv
hdl/idwt53_lift.sv
hdl/idwt53_outq.sv
hdl/inverse_dwt_53_reversible_line.sv
tb/tb_inverse_dwt_53_reversible_line.sv
